// ===== rtl/rtcb_pkg.sv =====
package rtcb_pkg;

  localparam int TICKS_PER_SECOND = 20;

  localparam int SUB_W    = 5;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam int SEC_LIMIT   = 60;
  localparam int MIN_LIMIT   = 60;
  localparam int HOUR_LIMIT  = 24;
  localparam int MONTH_LIMIT = 12;
  localparam int YEAR_MAX    = 9999;
  localparam int CENTURY     = 100;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ONE_HOUR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ONE_MINUTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TWO_MINUTE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THREE_MINUTE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_FOUR_HOUR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_FOUR_MINUTE  = 3'd5;

  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } time_t;

  typedef struct packed {
    logic [HOUR_W-1:0] one_hour;
    logic [MIN_W-1:0]  one_minute;
    logic [MIN_W-1:0]  two_minute;
    logic [MIN_W-1:0]  three_minute;
    logic [HOUR_W-1:0] four_hour;
    logic [MIN_W-1:0]  four_minute;
  } alarm_cfg_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    begin
      case (m)
        4'd2: begin
          d = leap ? 5'd29 : 5'd28;
        end
        4'd4, 4'd6, 4'd9, 4'd11: begin
          d = 5'd30;
        end
        default: begin
          d = 5'd31;
        end
      endcase
      return d;
    end
  endfunction

endpackage

// ===== rtl/rtcb_bell.sv =====
module rtcb_bell (
  input  rtcb_pkg::time_t      cur,
  input  rtcb_pkg::alarm_cfg_t alarm,
  output logic                 bell
);

  logic school;
  logic hit_one;
  logic hit_four;
  logic hit_hourly;

  always_comb begin
    school     = cur.hour inside {[5'd7:5'd12], [5'd14:5'd21]};
    hit_one    = (cur.minute == alarm.one_minute) && (cur.hour == alarm.one_hour);
    hit_four   = (cur.minute == alarm.four_minute) && (cur.hour == alarm.four_hour);
    hit_hourly = school && ((cur.minute == alarm.two_minute) ||
                            (cur.minute == alarm.three_minute));
    bell       = hit_one || hit_four || hit_hourly;
  end

endmodule

// ===== rtl/rtcb_time.sv =====
module rtcb_time (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic            tick,
  output rtcb_pkg::time_t cur,
  output rtcb_pkg::time_t nxt
);

  logic [rtcb_pkg::SUB_W-1:0] sub_r, sub_nxt, sub_inc;
  rtcb_pkg::time_t            t_r, t_nxt;
  // The year is also kept as its value modulo 100 and its century modulo 4,
  // so the leap test needs no division.
  logic [6:0]                 yr_lo_r, yr_lo_nxt;
  logic [1:0]                 yr_cen_r, yr_cen_nxt;

  logic        sec_carry;
  logic        leap;
  logic [6:0]  s_inc, m_inc;
  logic [5:0]  h_inc, d_inc;
  logic [4:0]  mo_inc;
  logic [14:0] y_inc;
  logic        year_step, year_wrap;

  always_comb begin
    leap      = (yr_lo_r[1:0] == 2'd0) && ((yr_lo_r != 7'd0) || (yr_cen_r == 2'd0));
    sub_inc   = sub_r + 5'd1;
    sec_carry = tick && (sub_inc >= rtcb_pkg::SUB_W'(rtcb_pkg::TICKS_PER_SECOND));
    sub_nxt   = sub_r;
    if (tick) begin
      sub_nxt = sec_carry ? '0 : sub_inc;
    end

    t_nxt      = t_r;
    yr_lo_nxt  = yr_lo_r;
    yr_cen_nxt = yr_cen_r;
    s_inc      = {1'b0, t_r.second} + 7'd1;
    m_inc      = {1'b0, t_r.minute};
    h_inc      = {1'b0, t_r.hour};
    d_inc      = {1'b0, t_r.day};
    mo_inc     = {1'b0, t_r.month};
    y_inc      = {1'b0, t_r.year};
    year_step  = 1'b0;
    year_wrap  = 1'b0;

    if (sec_carry) begin
      if (s_inc >= 7'(rtcb_pkg::SEC_LIMIT)) begin
        t_nxt.second = '0;
        m_inc        = m_inc + 7'd1;
      end else begin
        t_nxt.second = s_inc[5:0];
      end
      if (m_inc >= 7'(rtcb_pkg::MIN_LIMIT)) begin
        t_nxt.minute = '0;
        h_inc        = h_inc + 6'd1;
      end else begin
        t_nxt.minute = m_inc[5:0];
      end
      if (h_inc >= 6'(rtcb_pkg::HOUR_LIMIT)) begin
        t_nxt.hour = '0;
        d_inc      = d_inc + 6'd1;
      end else begin
        t_nxt.hour = h_inc[4:0];
      end
      if (d_inc > {1'b0, rtcb_pkg::month_days(t_r.month, leap)}) begin
        t_nxt.day = 5'd1;
        mo_inc    = mo_inc + 5'd1;
      end else begin
        t_nxt.day = d_inc[4:0];
      end
      if (mo_inc > 5'(rtcb_pkg::MONTH_LIMIT)) begin
        t_nxt.month = 4'd1;
        y_inc       = y_inc + 15'd1;
        year_step   = 1'b1;
      end else begin
        t_nxt.month = mo_inc[3:0];
      end
      if (y_inc > 15'(rtcb_pkg::YEAR_MAX)) begin
        t_nxt.year = '0;
        year_wrap  = 1'b1;
      end else begin
        t_nxt.year = y_inc[13:0];
      end
    end

    if (year_wrap) begin
      yr_lo_nxt  = '0;
      yr_cen_nxt = '0;
    end else if (year_step) begin
      if (yr_lo_r == 7'(rtcb_pkg::CENTURY - 1)) begin
        yr_lo_nxt  = '0;
        yr_cen_nxt = yr_cen_r + 2'd1;
      end else begin
        yr_lo_nxt = yr_lo_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r        <= '0;
      t_r.second   <= '0;
      t_r.minute   <= 6'd59;
      t_r.hour     <= 5'd23;
      t_r.day      <= 5'd28;
      t_r.month    <= 4'd6;
      t_r.year     <= 14'd2019;
      yr_lo_r      <= 7'd19;
      yr_cen_r     <= 2'd0;
    end else if (step_en) begin
      sub_r    <= sub_nxt;
      t_r      <= t_nxt;
      yr_lo_r  <= yr_lo_nxt;
      yr_cen_r <= yr_cen_nxt;
    end
  end

  assign cur = t_r;
  assign nxt = t_nxt;

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r < rtcb_pkg::SUB_W'(rtcb_pkg::TICKS_PER_SECOND))
    else $error("subsecond count out of range");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !tick) |=> ($stable(t_r) && $stable(sub_r)))
    else $error("time changed on a request without a tick");

  a_year_shadow: assert property (@(posedge clk) disable iff (!rst_n)
    (yr_lo_r < 7'(rtcb_pkg::CENTURY)) && (t_r.second < 6'(rtcb_pkg::SEC_LIMIT)))
    else $error("year shadow or seconds out of range");

endmodule

// ===== rtl/calendar_clock_with_bell_alarms.sv =====
// Flow: a request accepted into the input register moves to the result register, with the
// calendar update, as soon as the result register is empty or being drained.
// Throughput: one request per cycle unless out_stall holds a full result register.
// Reset: synchronous, active-low rst_n; the time restarts at 23:59:00 on June 28,
// 2019, the alarms return to their defaults and both stages are emptied.
module calendar_clock_with_bell_alarms (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_tick,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_bell,
  output logic [rtcb_pkg::SEC_W-1:0]        out_second_now,
  output logic [rtcb_pkg::MIN_W-1:0]        out_minute_now,
  output logic [rtcb_pkg::HOUR_W-1:0]       out_hour_now,
  output logic [rtcb_pkg::DAY_W-1:0]        out_day_now,
  output logic [rtcb_pkg::MONTH_W-1:0]      out_month_now,
  output logic [rtcb_pkg::YEAR_W-1:0]       out_year_now,
  input  logic                              cfg_we,
  input  logic [rtcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtcb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rtcb_pkg::alarm_cfg_t alarm_r;
  rtcb_pkg::time_t      cur_time;
  rtcb_pkg::time_t      nxt_time;
  rtcb_pkg::time_t      res_time_r;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_tick_r;
  logic out_valid_r, out_valid_nxt;
  logic res_bell_r;
  logic advance;
  logic step;
  logic in_accept;
  logic bell;

  // The result register can take a new result when empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? step : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tick_r <= in_tick;
    end
    if (step) begin
      res_bell_r <= bell;
      res_time_r <= nxt_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r.one_hour     <= 5'd6;
      alarm_r.one_minute   <= 6'd30;
      alarm_r.two_minute   <= 6'd0;
      alarm_r.three_minute <= 6'd50;
      alarm_r.four_hour    <= 5'd23;
      alarm_r.four_minute  <= 6'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        rtcb_pkg::CFG_ALARM_ONE_HOUR: begin
          alarm_r.one_hour <= cfg_data[rtcb_pkg::HOUR_W-1:0];
        end
        rtcb_pkg::CFG_ALARM_ONE_MINUTE: begin
          alarm_r.one_minute <= cfg_data[rtcb_pkg::MIN_W-1:0];
        end
        rtcb_pkg::CFG_ALARM_TWO_MINUTE: begin
          alarm_r.two_minute <= cfg_data[rtcb_pkg::MIN_W-1:0];
        end
        rtcb_pkg::CFG_ALARM_THREE_MINUTE: begin
          alarm_r.three_minute <= cfg_data[rtcb_pkg::MIN_W-1:0];
        end
        rtcb_pkg::CFG_ALARM_FOUR_HOUR: begin
          alarm_r.four_hour <= cfg_data[rtcb_pkg::HOUR_W-1:0];
        end
        rtcb_pkg::CFG_ALARM_FOUR_MINUTE: begin
          alarm_r.four_minute <= cfg_data[rtcb_pkg::MIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  rtcb_time u_time (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .tick    (s1_tick_r),
    .cur     (cur_time),
    .nxt     (nxt_time)
  );

  // The bell looks at the time before this request is counted.
  rtcb_bell u_bell (
    .cur   (cur_time),
    .alarm (alarm_r),
    .bell  (bell)
  );

  assign out_valid      = out_valid_r;
  assign out_bell       = res_bell_r;
  assign out_second_now = res_time_r.second;
  assign out_minute_now = res_time_r.minute;
  assign out_hour_now   = res_time_r.hour;
  assign out_day_now    = res_time_r.day;
  assign out_month_now  = res_time_r.month;
  assign out_year_now   = res_time_r.year;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with no request waiting");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a request in the input stage");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(res_time_r) && $stable(res_bell_r)))
    else $error("stalled result changed");

endmodule
